// File: hw/rtl/pvs_pkg.sv
// Package for the PCM volume scaler: sample format codes, register indexes,
// divide-by-100 constants and the structs passed between the pipeline parts.
// Has no dependencies; every other RTL file of the block uses it.
`default_nettype none

package pvs_pkg;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 7;
  localparam logic [CFG_ADDR_W-1:0] REG_FORMAT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_VOLUME = 1'b1;

  // Sample format codes.
  localparam logic [2:0] FMT_S8  = 3'd0;
  localparam logic [2:0] FMT_U8  = 3'd1;
  localparam logic [2:0] FMT_S16 = 3'd2;
  localparam logic [2:0] FMT_S24 = 3'd3;
  localparam logic [2:0] FMT_S32 = 3'd4;

  localparam logic [2:0] FORMAT_RESET = FMT_S16;
  localparam logic [6:0] VOLUME_RESET = 7'd100;
  localparam logic [6:0] VOLUME_UNITY = 7'd100;

  // x / 100 == (x * DIV100_MAGIC) >> DIV100_SHIFT for any 32-bit x.
  localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
  localparam int unsigned DIV100_SHIFT = 37;
  // Quotient of a sample magnitude (at most 2^31) by 100 fits in 25 bits.
  localparam int unsigned QUOT_W = 25;
  // x / 100 == (x * FRAC_MAGIC) >> FRAC_SHIFT for x below 10000.
  localparam logic [13:0] FRAC_MAGIC = 14'd10486;
  localparam int unsigned FRAC_SHIFT = 20;

  // One classified input byte on its way through the scaling pipeline.
  typedef struct packed {
    logic        last;   // byte closed the buffer
    logic [2:0]  cnt;    // number of bytes this item emits, 0 to 4
    logic        scale;  // emit the scaled sample instead of the raw bytes
    logic [2:0]  fmt;
    logic [6:0]  vol;
    logic [31:0] raw;    // assembled little-endian bytes
    logic        neg;    // sample is negative
    logic [31:0] mag;    // sample magnitude
  } item_t;

  // A group of bytes handed to the output serializer.
  typedef struct packed {
    logic        vld;
    logic        last;
    logic [2:0]  cnt;
    logic [31:0] word;
  } burst_t;

endpackage

`default_nettype wire

// File: hw/rtl/pvs_assembler.sv
// Input register, sample assembly and classification for the volume scaler.
// Holds the partial sample state. Depends on pvs_pkg.
`default_nettype none

module pvs_assembler (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [2:0]     cfg_format_i,
  input  wire logic [6:0]     cfg_volume_i,
  input  wire logic           in_valid_i,
  input  wire logic [7:0]     in_byte_i,
  input  wire logic           in_last_i,
  input  wire logic           adv_i,
  output logic                item_vld_o,
  output pvs_pkg::item_t      item_o
);

  logic           in_vld_q;
  logic [7:0]     in_byte_q;
  logic           in_last_q;
  logic [1:0]     pcnt_q, pcnt_d;
  logic [23:0]    pend_q;
  logic           p2_vld_q;
  pvs_pkg::item_t p2_q, item_d;

  logic [31:0]        word;
  logic [2:0]         size;
  logic [2:0]         cnt1;
  logic               pass, hold, scale;
  logic signed [32:0] sv;
  logic [32:0]        sv_neg;

  always_comb begin
    case (pcnt_q)
      2'd0:    word = {24'b0, in_byte_q};
      2'd1:    word = {16'b0, in_byte_q, pend_q[7:0]};
      2'd2:    word = {8'b0, in_byte_q, pend_q[15:0]};
      default: word = {in_byte_q, pend_q};
    endcase
  end

  always_comb begin
    unique case (cfg_format_i)
      pvs_pkg::FMT_S8:  size = 3'd1;
      pvs_pkg::FMT_U8:  size = 3'd1;
      pvs_pkg::FMT_S16: size = 3'd2;
      pvs_pkg::FMT_S32: size = 3'd4;
      default:          size = 3'd0;
    endcase
  end

  assign cnt1  = {1'b0, pcnt_q} + 3'd1;
  // Held bytes that no longer fit a narrowed format go out unchanged.
  assign pass  = (cfg_volume_i >= pvs_pkg::VOLUME_UNITY) || (size == 3'd0) || (cnt1 > size);
  assign hold  = !pass && (cnt1 < size) && !in_last_q;
  assign scale = !pass && (cnt1 == size);
  assign pcnt_d = hold ? cnt1[1:0] : 2'd0;

  always_comb begin
    unique case (cfg_format_i)
      pvs_pkg::FMT_S8:  sv = $signed({{25{word[7]}}, word[7:0]});
      pvs_pkg::FMT_U8:  sv = $signed({{26{~word[7]}}, word[6:0]});
      pvs_pkg::FMT_S16: sv = $signed({{17{word[15]}}, word[15:0]});
      default:          sv = $signed({word[31], word});
    endcase
  end

  assign sv_neg = -sv;

  always_comb begin
    item_d.last  = in_last_q;
    item_d.cnt   = scale ? size : (hold ? 3'd0 : cnt1);
    item_d.scale = scale;
    item_d.fmt   = cfg_format_i;
    item_d.vol   = cfg_volume_i;
    item_d.raw   = word;
    item_d.neg   = sv[32];
    item_d.mag   = sv[32] ? sv_neg[31:0] : sv[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      pcnt_q   <= 2'd0;
    end else if (adv_i) begin
      in_vld_q <= in_valid_i;
      p2_vld_q <= in_vld_q;
      if (in_vld_q) begin
        pcnt_q <= pcnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
      p2_q      <= item_d;
      if (in_vld_q && hold) begin
        pend_q <= word[23:0];
      end
    end
  end

  assign item_vld_o = p2_vld_q;
  assign item_o     = p2_q;

endmodule

`default_nettype wire

// File: hw/rtl/pvs_scaler.sv
// Scaling pipeline of the volume scaler: magnitude times volume over 100,
// split as (mag / 100) * vol + ((mag % 100) * vol) / 100, then clamp. Uses pvs_pkg.
`default_nettype none

module pvs_scaler (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           item_vld_i,
  input  wire pvs_pkg::item_t item_i,
  input  wire logic           burst_ready_i,
  output logic                adv_o,
  output pvs_pkg::burst_t     burst_o
);

  logic           p3_vld_q, p4_vld_q, p5_vld_q;
  pvs_pkg::item_t p3_item_q, p4_item_q, p5_item_q;
  logic [pvs_pkg::QUOT_W-1:0] p3_quot_q;
  logic [6:0]     p4_rem_q;
  logic [31:0]    p4_qv_q, p5_qv_q;
  logic [13:0]    p5_rv_q;

  logic [63:0]        prod;
  logic [31:0]        quot100;
  logic [31:0]        rem_full;
  logic [31:0]        qv;
  logic [13:0]        rv;
  logic [27:0]        frac_prod;
  logic [31:0]        mag;
  logic signed [32:0] sv, lo, hi, res;
  logic [31:0]        packed_word;

  // Stage 3 input: quotient by 100 through a reciprocal multiply.
  assign prod = {32'b0, item_i.mag} * {32'b0, pvs_pkg::DIV100_MAGIC};

  // Stage 4 input: remainder and coarse product.
  assign quot100  = 32'(p3_quot_q) * 32'd100;
  assign rem_full = p3_item_q.mag - quot100;
  assign qv       = 32'(p3_quot_q) * 32'(p3_item_q.vol);

  // Stage 5 input: remainder times volume, below 10000.
  assign rv = {7'b0, p4_rem_q} * {7'b0, p4_item_q.vol};

  // Output of stage 5: fine part, sign, clamp and repacking.
  assign frac_prod = {14'b0, p5_rv_q} * {14'b0, pvs_pkg::FRAC_MAGIC};
  assign mag = p5_qv_q + 32'(frac_prod[27:pvs_pkg::FRAC_SHIFT]);
  assign sv  = p5_item_q.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  always_comb begin
    case (p5_item_q.fmt)
      pvs_pkg::FMT_S8, pvs_pkg::FMT_U8: begin
        lo = -33'sd128;
        hi = 33'sd127;
      end
      pvs_pkg::FMT_S16: begin
        lo = -33'sd32768;
        hi = 33'sd32767;
      end
      default: begin
        lo = -33'sd2147483648;
        hi = 33'sd2147483647;
      end
    endcase
  end

  always_comb begin
    if (sv > hi) begin
      res = hi;
    end else if (sv < lo) begin
      res = lo;
    end else begin
      res = sv;
    end
  end

  always_comb begin
    case (p5_item_q.fmt)
      pvs_pkg::FMT_S8:  packed_word = {24'b0, res[7:0]};
      pvs_pkg::FMT_U8:  packed_word = {24'b0, ~res[7], res[6:0]};
      pvs_pkg::FMT_S16: packed_word = {16'b0, res[15:0]};
      default:          packed_word = res[31:0];
    endcase
  end

  // Items that emit nothing never wait for the serializer.
  assign adv_o = !(p5_vld_q && (p5_item_q.cnt != 3'd0) && !burst_ready_i);

  always_comb begin
    burst_o.vld  = p5_vld_q && (p5_item_q.cnt != 3'd0);
    burst_o.last = p5_item_q.last;
    burst_o.cnt  = p5_item_q.cnt;
    burst_o.word = p5_item_q.scale ? packed_word : p5_item_q.raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
      p5_vld_q <= 1'b0;
    end else if (adv_o) begin
      p3_vld_q <= item_vld_i;
      p4_vld_q <= p3_vld_q;
      p5_vld_q <= p4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      p3_item_q <= item_i;
      p3_quot_q <= prod[pvs_pkg::DIV100_SHIFT +: pvs_pkg::QUOT_W];
      p4_item_q <= p3_item_q;
      p4_rem_q  <= rem_full[6:0];
      p4_qv_q   <= qv;
      p5_item_q <= p4_item_q;
      p5_rv_q   <= rv;
      p5_qv_q   <= p4_qv_q;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pvs_serializer.sv
// Output register of the volume scaler: takes a group of up to four bytes
// and sends them one word per cycle while out_ready_i is high, lowest byte first. Uses pvs_pkg.
`default_nettype none

module pvs_serializer (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire pvs_pkg::burst_t burst_i,
  output logic                 burst_ready_o,
  output logic                 out_valid_o,
  output logic [7:0]           out_byte_o,
  output logic                 out_run_last_o,
  output logic                 out_buf_end_o,
  input  wire logic            out_ready_i
);

  logic [2:0]  cnt_q;
  logic [31:0] word_q;
  logic        last_q;
  logic        fire, load;

  assign out_valid_o   = (cnt_q != 3'd0);
  assign fire          = out_valid_o && out_ready_i;
  // A new group may load in the cycle the final byte of the current one leaves.
  assign burst_ready_o = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ready_i);
  assign load          = burst_i.vld && burst_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else if (load) begin
      cnt_q <= burst_i.cnt;
    end else if (fire) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= burst_i.word;
      last_q <= burst_i.last;
    end else if (fire) begin
      word_q <= {8'b0, word_q[31:8]};
    end
  end

  assign out_byte_o     = word_q[7:0];
  assign out_run_last_o = (cnt_q == 3'd1);
  assign out_buf_end_o  = (cnt_q == 3'd1) && last_q;

endmodule

`default_nettype wire

// File: hw/rtl/pcm_volume_scaler.sv
// PCM volume scaler: one byte word in per cycle, up to one byte word out per cycle.
// Samples pass the input register, the item register, scaler stages 3 to 5 and the output register.
// Throughput: one input word per cycle sustained; the input stalls only while the
// output is held back or while held bytes are flushed together with the current byte.
// Reset clears the pipeline, the partial sample count, format (s16) and volume (100).
`default_nettype none

module pcm_volume_scaler (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration writes.
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [pvs_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [pvs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input byte stream.
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [7:0]                     s_axis_tdata_i,  // in_byte
  input  wire logic                           s_axis_tlast_i,  // buffer_last
  // Output byte stream.
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [7:0]                          m_axis_tdata_o,  // out_byte
  output logic                                m_axis_tlast_o,  // buffer_end
  output logic                                m_axis_tuser_o   // run_last
);

  logic [2:0]      format_q;
  logic [6:0]      volume_q;
  logic            adv;
  logic            item_vld;
  pvs_pkg::item_t  item;
  pvs_pkg::burst_t burst;
  logic            burst_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= pvs_pkg::FORMAT_RESET;
      volume_q <= pvs_pkg::VOLUME_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        pvs_pkg::REG_FORMAT: format_q <= cfg_data_i[2:0];
        pvs_pkg::REG_VOLUME: volume_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = adv;

  pvs_assembler u_assembler (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_format_i (format_q),
    .cfg_volume_i (volume_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_byte_i    (s_axis_tdata_i),
    .in_last_i    (s_axis_tlast_i),
    .adv_i        (adv),
    .item_vld_o   (item_vld),
    .item_o       (item)
  );

  pvs_scaler u_scaler (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_vld_i    (item_vld),
    .item_i        (item),
    .burst_ready_i (burst_ready),
    .adv_o         (adv),
    .burst_o       (burst)
  );

  pvs_serializer u_serializer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .burst_i        (burst),
    .burst_ready_o  (burst_ready),
    .out_valid_o    (m_axis_tvalid_o),
    .out_byte_o     (m_axis_tdata_o),
    .out_run_last_o (m_axis_tuser_o),
    .out_buf_end_o  (m_axis_tlast_o),
    .out_ready_i    (m_axis_tready_i)
  );

endmodule

`default_nettype wire

// File: tb/pcm_volume_scaler_tb.sv
// Self-checking testbench for the PCM volume scaler: byte stream in, byte stream out.
// Keeps its own model of sample assembly and scaling and checks every output word.
// Depends on pvs_pkg and the pcm_volume_scaler RTL.
`timescale 1ns / 1ps

module pcm_volume_scaler_tb;

  localparam int unsigned CFG_ADDR_W = pvs_pkg::CFG_ADDR_W;
  localparam int unsigned CFG_DATA_W = pvs_pkg::CFG_DATA_W;
  // Any code above FMT_S32 is an unknown format that passes bytes through.
  localparam logic [2:0] FMT_RAW = 3'd5;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pcm_byte_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       buffer_end;
  } out_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = '0;  // in_byte
  logic       s_axis_tlast_i = 1'b0;  // buffer_last

  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;  // out_byte
  logic       m_axis_tlast_o;  // buffer_end
  logic       m_axis_tuser_o;  // run_last

  pcm_volume_scaler DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Model state: configuration and the partial sample held between bytes.
  logic [2:0]  cur_fmt = pvs_pkg::FORMAT_RESET;
  logic [6:0]  cur_vol = pvs_pkg::VOLUME_RESET;
  logic [23:0] held_bytes = '0;
  int unsigned held_count = 0;

  pcm_byte_t   pcm_queue[$];
  out_word_t   expected_words[$];
  pcm_byte_t   next_byte;
  out_word_t   exp_word;
  int unsigned bytes_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned gap_pct = 0;
  int unsigned src_gap = 0;
  int unsigned sink_stall = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Bytes per sample; zero for the formats that pass bytes straight through.
  function automatic int unsigned sample_bytes(logic [2:0] fmt);
    case (fmt)
      pvs_pkg::FMT_S8, pvs_pkg::FMT_U8: return 1;
      pvs_pkg::FMT_S16: return 2;
      pvs_pkg::FMT_S32: return 4;
      default: return 0;
    endcase
  endfunction

  function automatic logic [31:0] scale_sample(logic [31:0] raw);
    logic signed [63:0] v;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    case (cur_fmt)
      pvs_pkg::FMT_S8: begin
        v = $signed(raw[7:0]);
        lo = -64'sd128;
        hi = 64'sd127;
      end
      pvs_pkg::FMT_U8: begin
        v = longint'(raw[7:0]) - 128;
        lo = -64'sd128;
        hi = 64'sd127;
      end
      pvs_pkg::FMT_S16: begin
        v = $signed(raw[15:0]);
        lo = -64'sd32768;
        hi = 64'sd32767;
      end
      default: begin
        v = $signed(raw);
        lo = -64'sd2147483648;
        hi = 64'sd2147483647;
      end
    endcase
    // Signed division truncates toward zero.
    v = v * longint'(cur_vol) / 100;
    if (v > hi) v = hi;
    else if (v < lo) v = lo;
    if (cur_fmt == pvs_pkg::FMT_U8) v = v + 128;
    return v[31:0];
  endfunction

  // Works out the output words that one accepted input byte causes.
  function automatic void predict_byte(logic [7:0] b, logic last);
    int unsigned n;
    int unsigned n_out;
    logic [31:0] word;
    out_word_t   w;
    n = sample_bytes(cur_fmt);
    word = (32'(held_bytes) & ((32'd1 << (8 * held_count)) - 32'd1))
           | (32'(b) << (8 * held_count));
    n_out = 0;
    if (cur_vol >= pvs_pkg::VOLUME_UNITY || n == 0 || held_count + 1 > n) begin
      n_out = held_count + 1;
      held_count = 0;
    end else if (held_count + 1 < n) begin
      if (last) begin
        n_out = held_count + 1;
        held_count = 0;
      end else begin
        held_bytes = word[23:0];
        held_count = held_count + 1;
      end
    end else begin
      held_count = 0;
      word = scale_sample(word);
      n_out = n;
    end
    for (int unsigned i = 0; i < n_out; i++) begin
      w.out_byte = word[8*i +: 8];
      w.run_last = (i + 1 == n_out);
      w.buffer_end = (i + 1 == n_out) && last;
      expected_words.push_back(w);
    end
  endfunction

  // Input side: presents queued bytes, with random gaps between words.
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      predict_byte(s_axis_tdata_i, s_axis_tlast_i);
      bytes_accepted++;
    end
    if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (src_gap == 0 && gap_pct != 0 && $urandom_range(99) < gap_pct)
        src_gap = $urandom_range(1, 3);
      if (!rst_ni || src_gap != 0 || pcm_queue.size() == 0) begin
        s_axis_tvalid_i <= 1'b0;
        if (src_gap != 0) src_gap--;
      end else begin
        next_byte = pcm_queue.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= next_byte.data;
        s_axis_tlast_i <= next_byte.last;
      end
    end
  end

  // Output side: random back-pressure and comparison against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_words.size() == 0) begin
        $error("unexpected output word: out_byte %0h", m_axis_tdata_o);
        error_count++;
      end else begin
        exp_word = expected_words.pop_front();
        if (m_axis_tdata_o !== exp_word.out_byte) begin
          $error("out_byte: expected %0h, actual %0h", exp_word.out_byte, m_axis_tdata_o);
          error_count++;
        end
        if (m_axis_tuser_o !== exp_word.run_last) begin
          $error("run_last: expected %0b, actual %0b", exp_word.run_last, m_axis_tuser_o);
          error_count++;
        end
        if (m_axis_tlast_o !== exp_word.buffer_end) begin
          $error("buffer_end: expected %0b, actual %0b", exp_word.buffer_end, m_axis_tlast_o);
          error_count++;
        end
      end
    end
    if (sink_stall == 0 && gap_pct != 0 && $urandom_range(99) < gap_pct)
      sink_stall = $urandom_range(1, 3);
    if (!rst_ni || sink_stall != 0) begin
      m_axis_tready_i <= 1'b0;
      if (sink_stall != 0) sink_stall--;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_byte(logic [7:0] b, logic last);
    pcm_byte_t p;
    p.data = b;
    p.last = last;
    pcm_queue.push_back(p);
    bytes_queued++;
  endtask

  // Returns once every byte is in and every predicted word is out, plus a
  // margin for a byte that is only being held and causes no output.
  task automatic wait_drained();
    while (bytes_accepted != bytes_queued || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == pvs_pkg::REG_FORMAT) cur_fmt = val[2:0];
    else cur_vol = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [2:0] fmt, logic [6:0] vol);
    wait_drained();
    write_reg(pvs_pkg::REG_FORMAT, CFG_DATA_W'(fmt));
    write_reg(pvs_pkg::REG_VOLUME, vol);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly whole buffers of complete samples, some cut short mid-sample,
  // and some loose bytes with random end markers.
  task automatic queue_traffic(int unsigned n_bytes);
    int unsigned added;
    int unsigned sz;
    int unsigned len;
    int unsigned kind;
    added = 0;
    while (added < n_bytes) begin
      sz = sample_bytes(cur_fmt);
      if (sz == 0) sz = $urandom_range(1, 4);
      kind = $urandom_range(9);
      if (kind == 0) begin
        len = $urandom_range(1, 5);
        for (int unsigned i = 0; i < len; i++)
          add_byte(pick_byte(), $urandom_range(2) == 0);
      end else begin
        len = sz * $urandom_range(1, 6);
        if (kind == 1 && sz > 1) len = len + $urandom_range(1, sz - 1);
        for (int unsigned i = 0; i < len; i++)
          add_byte(pick_byte(), i + 1 == len);
      end
      added = added + len;
    end
  endtask

  initial begin
    logic [2:0] fmt;
    logic [6:0] vol;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part. Reset settings pass bytes through one at a time.
    gap_pct = 30;
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    // Signed 16-bit extremes at half volume.
    set_config(pvs_pkg::FMT_S16, 7'd50);
    add_byte(8'h00, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h7F, 1'b1);
    // Mute on signed 8-bit samples, then offset 8-bit samples at volume 37.
    set_config(pvs_pkg::FMT_S8, 7'd0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h7F, 1'b1);
    set_config(pvs_pkg::FMT_U8, 7'd37);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    // Most negative 32-bit sample, then a buffer that ends mid-sample.
    set_config(pvs_pkg::FMT_S32, 7'd1);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h12, 1'b0);
    add_byte(8'h34, 1'b1);
    // Three bytes held, then the format shrinks below the held count.
    set_config(pvs_pkg::FMT_S32, 7'd50);
    add_byte(8'hAA, 1'b0);
    add_byte(8'hBB, 1'b0);
    add_byte(8'hCC, 1'b0);
    set_config(pvs_pkg::FMT_S16, 7'd50);
    add_byte(8'hDD, 1'b0);
    // One byte held, then volume switches to passthrough.
    add_byte(8'h11, 1'b0);
    set_config(pvs_pkg::FMT_S16, pvs_pkg::VOLUME_UNITY);
    add_byte(8'h22, 1'b0);
    set_config(pvs_pkg::FMT_S24, 7'd50);
    add_byte(8'h01, 1'b0);
    add_byte(8'hFE, 1'b1);
    set_config(FMT_RAW, 7'd50);
    add_byte(8'h55, 1'b0);
    add_byte(8'hAA, 1'b1);

    // Random part: each setting gets its own stretch of traffic.
    for (int unsigned ph = 0; ph < 12; ph++) begin
      if (ph < 6) fmt = 3'(ph);
      else fmt = 3'($urandom_range(0, 5));
      case ($urandom_range(5))
        0: vol = 7'd0;
        1: vol = pvs_pkg::VOLUME_UNITY;
        2: vol = 7'd99;
        default: vol = 7'($urandom_range(1, 98));
      endcase
      if (ph == 11) begin
        fmt = pvs_pkg::FMT_S16;
        vol = 7'd99;
      end
      set_config(fmt, vol);
      case (ph % 3)
        0: gap_pct = 0;
        1: gap_pct = 25;
        default: gap_pct = 50;
      endcase
      if (ph == 11) gap_pct = 0;
      queue_traffic(10);
      // Hold the sender back until the block has caught up.
      if (ph % 2 == 0) wait_drained();
      queue_traffic(10);
    end

    wait_drained();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
